// ===== rtl/mdp_pkg.sv =====
`timescale 1ns / 1ps

package mdp_pkg;

  // Field and state widths
  localparam int PIX_W       = 8;
  localparam int LUMA_W      = 12;
  localparam int ERR_W       = 12;
  localparam int SUM_W       = 15;
  localparam int WORD_W      = 16;
  localparam int BIT_POS_W   = 4;
  localparam int ROW_WIDTH_W = 12;
  localparam int REPEAT_W    = 2;

  localparam int DEF_MAX_WIDTH = 2048;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Thresholds and full-scale values
  localparam int GRAY_THRESH = 'h80;
  localparam int GRAY_SCALE  = 'hFF;
  localparam int RGB_THRESH  = 2040;
  localparam int RGB_SCALE   = 4080;

  // Register reset values
  localparam logic                   COLOR_MODE_RST  = 1'b0;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST   = ROW_WIDTH_W'(640);
  localparam logic [REPEAT_W-1:0]    WORD_REPEAT_RST = REPEAT_W'(1);
  localparam logic [BIT_POS_W-1:0]   BIT_POS_MSB     = BIT_POS_W'(WORD_W - 1);

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_COLOR_MODE  = 2'd0,
    REG_ROW_WIDTH   = 2'd1,
    REG_WORD_REPEAT = 2'd2
  } mdp_reg_t;

endpackage

// ===== rtl/mdp_col_store.sv =====
`timescale 1ns / 1ps

// Per-column error row memory. One read and one write port, registered read.
// A fill count marks the written prefix; columns past it read as zero.
// The last write is kept so a read that raced it still sees fresh data.
module mdp_col_store
  import mdp_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
  output logic signed [ERR_W-1:0]         rd_data,
  input  logic                            wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
  input  logic signed [ERR_W-1:0]         wr_data
);

  localparam int IW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 1);

  logic signed [ERR_W-1:0] mem [MAX_WIDTH];
  logic signed [ERR_W-1:0] mem_q;
  logic [IW-1:0]           raddr_q;
  logic [IW-1:0]           last_addr;
  logic signed [ERR_W-1:0] last_data;
  logic [FW-1:0]           fill;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_addr];
      raddr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_addr <= wr_addr;
      last_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_en && (FW'(wr_addr) == fill)) begin
      fill <= fill + FW'(1);
    end
  end

  always_comb begin
    if (FW'(raddr_q) >= fill) begin
      rd_data = '0;
    end else if (last_addr == raddr_q) begin
      rd_data = last_data;
    end else begin
      rd_data = mem_q;
    end
  end

endmodule

// ===== rtl/mono_error_diffusion_packer.sv =====
`timescale 1ns / 1ps
// A word is registered as its closing pixel leaves stage A; a repeated word is sent twice.
// Throughput: one pixel per cycle unless stage A waits on the output. The column error
// RAM is read at accept and written back when stage A fires, the last write forwarded.
// Reset (rst, synchronous): control, counters, running error and registers go to defaults.
// The column error RAM is not swept; a fill count reads never-written columns as zero.
module mono_error_diffusion_packer
  import mdp_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready,
  // pixel input
  input  logic                    pixel_valid,
  output logic                    pixel_stall,
  input  logic [PIX_W-1:0]        red_or_gray,
  input  logic [PIX_W-1:0]        green,
  input  logic [PIX_W-1:0]        blue,
  input  logic                    first_row,
  // packed word output
  output logic                    word_valid,
  input  logic                    word_stall,
  output logic [WORD_W-1:0]       packed_word,
  output logic                    end_of_row,
  output logic                    last_of_run
);

  localparam int CW = $clog2(MAX_WIDTH);
  // compare width: holds both the row_width register and MAX_WIDTH
  localparam int WW = (CW + 1 > ROW_WIDTH_W) ? CW + 1 : ROW_WIDTH_W;

  localparam logic signed [SUM_W-1:0] GRAY_THR_S = SUM_W'(GRAY_THRESH);
  localparam logic signed [SUM_W-1:0] GRAY_SCL_S = SUM_W'(GRAY_SCALE);
  localparam logic signed [SUM_W-1:0] RGB_THR_S  = SUM_W'(RGB_THRESH);
  localparam logic signed [SUM_W-1:0] RGB_SCL_S  = SUM_W'(RGB_SCALE);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                   color_mode;
  logic [ROW_WIDTH_W-1:0] row_width;
  logic [REPEAT_W-1:0]    word_repeat;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode  <= COLOR_MODE_RST;
      row_width   <= ROW_WIDTH_RST;
      word_repeat <= WORD_REPEAT_RST;
    end else if (cfg_wr) begin
      case (mdp_reg_t'(paddr[3:2]))
        REG_COLOR_MODE:  color_mode  <= pwdata[0];
        REG_ROW_WIDTH:   row_width   <= pwdata[ROW_WIDTH_W-1:0];
        REG_WORD_REPEAT: word_repeat <= pwdata[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mdp_reg_t'(paddr[3:2]))
      REG_COLOR_MODE:  prdata = APB_DATA_W'(color_mode);
      REG_ROW_WIDTH:   prdata = APB_DATA_W'(row_width);
      REG_WORD_REPEAT: prdata = APB_DATA_W'(word_repeat);
      default:         prdata = '0;
    endcase
  end

  // Effective row width: zero acts as one, saturate at MAX_WIDTH.
  logic [WW-1:0] width_eff;

  always_comb begin
    if (row_width == '0) begin
      width_eff = WW'(1);
    end else if (WW'(row_width) > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(row_width);
    end
  end

  // ---------------------------------------------------------------------------
  // Accept side: column/bit counters, luma, RAM read
  // ---------------------------------------------------------------------------
  logic                  pixel_take;
  logic [CW-1:0]         column_index;
  logic [BIT_POS_W-1:0]  bit_position;
  logic [WW-1:0]         col_plus;
  logic                  row_end_in;
  logic                  emit_in;
  logic [LUMA_W-1:0]     luma_in;
  logic [LUMA_W-1:0]     r_ext, g_ext, b_ext;

  // stage A holds one pixel while its error is resolved
  logic                  a_valid;
  logic                  a_fire;
  logic [LUMA_W-1:0]     a_luma;
  logic                  a_first;
  logic [CW-1:0]         a_col;
  logic                  a_row_end;
  logic                  a_emit;
  logic [BIT_POS_W-1:0]  a_bitpos;

  logic                  out_free;
  logic                  more;

  assign pixel_stall = a_valid && !a_fire;
  assign pixel_take  = pixel_valid && !pixel_stall;

  assign col_plus   = WW'(column_index) + WW'(1);
  assign row_end_in = (col_plus >= width_eff);
  assign emit_in    = row_end_in || (bit_position == '0);

  // 5R + 9G + 2B by shift-add; max 4080
  assign r_ext = LUMA_W'(red_or_gray);
  assign g_ext = LUMA_W'(green);
  assign b_ext = LUMA_W'(blue);

  always_comb begin
    if (color_mode) begin
      luma_in = (r_ext << 2) + r_ext + (g_ext << 3) + g_ext + (b_ext << 1);
    end else begin
      luma_in = r_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      bit_position <= BIT_POS_MSB;
    end else if (pixel_take) begin
      column_index <= row_end_in ? '0 : col_plus[CW-1:0];
      bit_position <= emit_in ? BIT_POS_MSB : bit_position - BIT_POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pixel_take) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      a_luma    <= luma_in;
      a_first   <= first_row;
      a_col     <= column_index;
      a_row_end <= row_end_in;
      a_emit    <= emit_in;
      a_bitpos  <= bit_position;
    end
  end

  // ---------------------------------------------------------------------------
  // Column error RAM
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0] stored_raw;
  logic signed [ERR_W-1:0] err_new;

  mdp_col_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_col_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (pixel_take),
    .rd_addr (column_index),
    .rd_data (stored_raw),
    .wr_en   (a_fire),
    .wr_addr (a_col),
    .wr_data (err_new)
  );

  // ---------------------------------------------------------------------------
  // Diffusion: sum, threshold, quarter error (floor via arithmetic shift)
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0] running_error;
  logic signed [ERR_W-1:0] stored;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_adj;
  logic signed [SUM_W-1:0] thresh;
  logic signed [SUM_W-1:0] scale;
  logic                    dark;
  logic [WORD_W-1:0]       partial_word;
  logic [WORD_W-1:0]       word_new;

  // non-emitting pixels never wait on the output side
  assign a_fire = a_valid && (!a_emit || out_free);

  always_comb begin
    stored  = a_first ? '0 : stored_raw;
    thresh  = color_mode ? RGB_THR_S : GRAY_THR_S;
    scale   = color_mode ? RGB_SCL_S : GRAY_SCL_S;
    sum     = SUM_W'(running_error) + SUM_W'(stored) + SUM_W'($signed({1'b0, a_luma}));
    dark    = (sum < thresh);
    sum_adj = dark ? sum : sum - scale;
    err_new = ERR_W'(sum_adj >>> 2);
    word_new = partial_word | (dark ? (WORD_W'(1) << a_bitpos) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_error <= '0;
      partial_word  <= '0;
    end else if (a_fire) begin
      running_error <= a_row_end ? '0 : err_new;
      partial_word  <= a_emit ? '0 : word_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register; 'more' marks a second copy still to go
  // ---------------------------------------------------------------------------
  assign out_free    = !word_valid || (!word_stall && !more);
  assign last_of_run = !more;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      more       <= 1'b0;
    end else if (a_fire && a_emit) begin
      word_valid <= 1'b1;
      more       <= word_repeat[1];
    end else if (word_valid && !word_stall) begin
      if (more) begin
        more <= 1'b0;
      end else begin
        word_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_emit) begin
      packed_word <= word_new;
      end_of_row  <= a_row_end;
    end
  end

endmodule
